FILE: rtl/edm_pkg.sv
// ----------------------------------------------------------------------------
// Euclidean distance matrix package
// Sizes, field widths, codes and the control word of the microcoded sequencer.
// ----------------------------------------------------------------------------
package edm_pkg;

   localparam int MAX_RECORDS = 16;
   localparam int MAX_DIMS    = 64;
   localparam int ELEM_BITS   = 16;

   localparam int REC_IDX_W  = $clog2(MAX_RECORDS);
   localparam int DIM_IDX_W  = $clog2(MAX_DIMS);
   localparam int DIM_CNT_W  = $clog2(MAX_DIMS + 1);
   localparam int ADDR_W     = REC_IDX_W + DIM_IDX_W;
   localparam int MEM_DEPTH  = MAX_RECORDS * MAX_DIMS;

   // Register and payload widths fixed by the interface.
   localparam int DIMS_REG_W = 7;
   localparam int DIMS_RESET = 64;
   localparam int DIST_W     = 19;
   localparam int STATUS_W   = 2;

   // Sum of squared differences and its root.
   localparam int SUM_W      = 2 * ELEM_BITS + DIM_IDX_W;
   localparam int ROOT_W     = (SUM_W + 1) / 2;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   // Microprogram address width.
   localparam int UPC_W      = 4;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_WRITE_OK   = 2'd0,
      ST_DIST_OK    = 2'd1,
      ST_NOT_LOADED = 2'd2
   } status_type;

   // Datapath action selected by the current control word.
   typedef enum logic [2:0] {
      ACT_NOP       = 3'd0,
      ACT_IDLE      = 3'd1,
      ACT_CLEAR     = 3'd2,
      ACT_ISSUE     = 3'd3,
      ACT_ROOT_LOAD = 3'd4,
      ACT_ROOT_STEP = 3'd5,
      ACT_EMIT      = 3'd6
   } act_type;

   // Jump condition of the control word.
   typedef enum logic [2:0] {
      COND_NEVER     = 3'd0,
      COND_ALWAYS    = 3'd1,
      COND_NO_FIRE   = 3'd2,
      COND_NOT_QUERY = 3'd3,
      COND_NO_DIMS   = 3'd4,
      COND_MORE      = 3'd5,
      COND_ROOT_MORE = 3'd6,
      COND_RSP_BUSY  = 3'd7
   } cond_sel_type;

   typedef struct packed {
      act_type            act;
      cond_sel_type       cond;
      logic [UPC_W-1:0]   target;
   } edm_ctl_type;

   // Flags the datapath reports back to the sequencer.
   typedef struct packed {
      logic fire;
      logic not_query;
      logic no_dims;
      logic more;
      logic root_more;
      logic rsp_busy;
   } edm_cond_type;

endpackage

FILE: rtl/edm_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one write or query item.
// ----------------------------------------------------------------------------
interface edm_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [3:0]         record_index;
   logic [5:0]         element_index;
   logic signed [15:0] element_value;
   logic [3:0]         other_index;

   modport source (
      output valid, op, record_index, element_index, element_value, other_index,
      input  ready
   );
   modport sink (
      input  valid, op, record_index, element_index, element_value, other_index,
      output ready
   );
endinterface

FILE: rtl/edm_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one distance and status per item.
// ----------------------------------------------------------------------------
interface edm_rsp_if;
   logic        valid;
   logic        ready;
   logic [18:0] distance;
   logic [1:0]  status;

   modport source (
      output valid, distance, status,
      input  ready
   );
   modport sink (
      input  valid, distance, status,
      output ready
   );
endinterface

FILE: rtl/edm_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the dimension count register.
// ----------------------------------------------------------------------------
interface edm_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface

FILE: rtl/edm_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floored root of the sum of squares, one result bit per ROOT_STEP cycle.
// ----------------------------------------------------------------------------
module edm_isqrt
   import edm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  act_type           act,
   input  logic [SUM_W-1:0]  value,
   output logic [ROOT_W-1:0] root,
   output logic              more
);

   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [SUM_W-1:0]      root_ff, root_in;
   logic [SUM_W-1:0]      bit_ff, bit_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]      trial;

   assign trial = root_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      case (act)
         ACT_ROOT_LOAD: begin
            rem_in  = value;
            root_in = '0;
            // Highest power of four that the sum can reach.
            bit_in  = SUM_W'(1) << (2 * (ROOT_W - 1));
            cnt_in  = '0;
         end
         ACT_ROOT_STEP: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign root = root_ff[ROOT_W-1:0];
   assign more = (cnt_ff != ROOT_CNT_W'(ROOT_W - 1));

endmodule

FILE: rtl/edm_sequencer.sv
// ----------------------------------------------------------------------------
// Microcoded sequencer
// Step counter over a read-only program with conditional jumps.
// ----------------------------------------------------------------------------
module edm_sequencer
   import edm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  edm_cond_type cond,
   output edm_ctl_type  ctl
);

   localparam logic [UPC_W-1:0] STEP_IDLE     = UPC_W'(0);
   localparam logic [UPC_W-1:0] STEP_DISPATCH = UPC_W'(1);
   localparam logic [UPC_W-1:0] STEP_CLEAR    = UPC_W'(2);
   localparam logic [UPC_W-1:0] STEP_LOOP     = UPC_W'(3);
   localparam logic [UPC_W-1:0] STEP_DRAIN0   = UPC_W'(4);
   localparam logic [UPC_W-1:0] STEP_DRAIN1   = UPC_W'(5);
   localparam logic [UPC_W-1:0] STEP_DRAIN2   = UPC_W'(6);
   localparam logic [UPC_W-1:0] STEP_ROOT0    = UPC_W'(7);
   localparam logic [UPC_W-1:0] STEP_ROOT     = UPC_W'(8);
   localparam logic [UPC_W-1:0] STEP_EMIT     = UPC_W'(9);
   localparam logic [UPC_W-1:0] STEP_RETURN   = UPC_W'(10);

   function automatic edm_ctl_type program_word(input logic [UPC_W-1:0] addr);
      edm_ctl_type w;
      case (addr)
         STEP_IDLE:     w = '{act: ACT_IDLE,      cond: COND_NO_FIRE,   target: STEP_IDLE};
         STEP_DISPATCH: w = '{act: ACT_NOP,       cond: COND_NOT_QUERY, target: STEP_EMIT};
         STEP_CLEAR:    w = '{act: ACT_CLEAR,     cond: COND_NO_DIMS,   target: STEP_DRAIN0};
         STEP_LOOP:     w = '{act: ACT_ISSUE,     cond: COND_MORE,      target: STEP_LOOP};
         // Three steps let the last element pass read, difference and square.
         STEP_DRAIN0:   w = '{act: ACT_NOP,       cond: COND_NEVER,     target: STEP_IDLE};
         STEP_DRAIN1:   w = '{act: ACT_NOP,       cond: COND_NEVER,     target: STEP_IDLE};
         STEP_DRAIN2:   w = '{act: ACT_NOP,       cond: COND_NEVER,     target: STEP_IDLE};
         STEP_ROOT0:    w = '{act: ACT_ROOT_LOAD, cond: COND_NEVER,     target: STEP_IDLE};
         STEP_ROOT:     w = '{act: ACT_ROOT_STEP, cond: COND_ROOT_MORE, target: STEP_ROOT};
         STEP_EMIT:     w = '{act: ACT_EMIT,      cond: COND_RSP_BUSY,  target: STEP_EMIT};
         STEP_RETURN:   w = '{act: ACT_NOP,       cond: COND_ALWAYS,    target: STEP_IDLE};
         default:       w = '{act: ACT_NOP,       cond: COND_ALWAYS,    target: STEP_IDLE};
      endcase
      return w;
   endfunction

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             take_jump;

   assign ctl = program_word(upc_ff);

   always_comb begin
      case (ctl.cond)
         COND_NEVER:     take_jump = 1'b0;
         COND_ALWAYS:    take_jump = 1'b1;
         COND_NO_FIRE:   take_jump = !cond.fire;
         COND_NOT_QUERY: take_jump = cond.not_query;
         COND_NO_DIMS:   take_jump = cond.no_dims;
         COND_MORE:      take_jump = cond.more;
         COND_ROOT_MORE: take_jump = cond.root_more;
         COND_RSP_BUSY:  take_jump = cond.rsp_busy;
         default:        take_jump = 1'b1;
      endcase
      upc_in = take_jump ? ctl.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

FILE: rtl/edm_datapath.sv
// ----------------------------------------------------------------------------
// Distance datapath
// Record memory, loaded flags, difference/square/accumulate pipe, root unit
// and the response register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module edm_datapath
   import edm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   edm_req_if.sink      req_ch,
   edm_rsp_if.source    rsp_ch,
   edm_csr_if.sink      csr_ch,
   input  edm_ctl_type  ctl,
   output edm_cond_type cond
);

   logic [ELEM_BITS-1:0]  mem [MEM_DEPTH];

   logic [DIMS_REG_W-1:0] dims_ff;
   logic [MAX_RECORDS-1:0] loaded_ff;
   logic                  op_ff;
   logic [REC_IDX_W-1:0]  ri_ff;
   logic [REC_IDX_W-1:0]  oi_ff;
   logic [DIM_IDX_W-1:0]  k_ff;

   logic [ELEM_BITS-1:0]  rd_a_ff, rd_b_ff;
   logic [ELEM_BITS-1:0]  diff_ff, diff_in;
   logic [2*ELEM_BITS-1:0] sq_ff, sq_in;
   logic [SUM_W-1:0]      sum_ff;
   logic                  v1_ff, v2_ff, v3_ff;

   logic                  rsp_valid_ff;
   logic [DIST_W-1:0]     distance_ff;
   status_type            status_ff;

   logic                  fire;
   logic                  query_ok;
   logic [DIM_CNT_W-1:0]  n_use;
   logic [DIM_CNT_W-1:0]  k_next;
   logic signed [ELEM_BITS:0] diff_s;
   logic [ELEM_BITS:0]    diff_mag;
   logic [ROOT_W-1:0]     root;
   logic                  root_more;
   logic                  rsp_busy;

   assign req_ch.ready = (ctl.act == ACT_IDLE);
   assign fire         = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Dimension count, clamped to the store's width.
   assign n_use = (DIM_CNT_W'(dims_ff) > DIM_CNT_W'(MAX_DIMS)) ?
                  DIM_CNT_W'(MAX_DIMS) : DIM_CNT_W'(dims_ff);
   assign k_next   = DIM_CNT_W'(k_ff) + 1'b1;
   assign query_ok = loaded_ff[ri_ff] && loaded_ff[oi_ff];
   assign rsp_busy = rsp_valid_ff && !rsp_ch.ready;

   assign cond.fire      = fire;
   assign cond.not_query = (op_ff == OP_WRITE) || !query_ok;
   assign cond.no_dims   = (n_use == '0);
   assign cond.more      = (k_next < n_use);
   assign cond.root_more = root_more;
   assign cond.rsp_busy  = rsp_busy;

   // Absolute difference of two signed elements fits the element width unsigned.
   assign diff_s   = {rd_a_ff[ELEM_BITS-1], rd_a_ff} - {rd_b_ff[ELEM_BITS-1], rd_b_ff};
   assign diff_mag = diff_s[ELEM_BITS] ? (ELEM_BITS+1)'(-diff_s) : diff_s;
   assign diff_in  = diff_mag[ELEM_BITS-1:0];
   assign sq_in    = (2*ELEM_BITS)'(diff_ff) * (2*ELEM_BITS)'(diff_ff);

   // Record store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (fire && (req_ch.op == OP_WRITE)) begin
         mem[{req_ch.record_index, req_ch.element_index}] <= req_ch.element_value;
      end
      if (ctl.act == ACT_ISSUE) begin
         rd_a_ff <= mem[{ri_ff, k_ff}];
         rd_b_ff <= mem[{oi_ff, k_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= DIMS_REG_W'(DIMS_RESET);
         loaded_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            dims_ff <= csr_ch.data;
         end
         if (fire && (req_ch.op == OP_WRITE)) begin
            loaded_ff[req_ch.record_index] <= 1'b1;
         end
         v1_ff <= (ctl.act == ACT_ISSUE);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if ((ctl.act == ACT_EMIT) && !rsp_busy) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         op_ff <= req_ch.op;
         ri_ff <= req_ch.record_index;
         oi_ff <= req_ch.other_index;
      end
      if (ctl.act == ACT_CLEAR) begin
         k_ff <= '0;
      end else if (ctl.act == ACT_ISSUE) begin
         k_ff <= k_ff + 1'b1;
      end
      diff_ff <= diff_in;
      sq_ff   <= sq_in;
      if (ctl.act == ACT_CLEAR) begin
         sum_ff <= '0;
      end else if (v3_ff) begin
         sum_ff <= sum_ff + SUM_W'(sq_ff);
      end
      if ((ctl.act == ACT_EMIT) && !rsp_busy) begin
         if (op_ff == OP_WRITE) begin
            distance_ff <= '0;
            status_ff   <= ST_WRITE_OK;
         end else if (!query_ok) begin
            distance_ff <= '0;
            status_ff   <= ST_NOT_LOADED;
         end else begin
            distance_ff <= DIST_W'(root);
            status_ff   <= ST_DIST_OK;
         end
      end
   end

   edm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .act   (ctl.act),
      .value (sum_ff),
      .root  (root),
      .more  (root_more)
   );

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = distance_ff;
   assign rsp_ch.status   = status_ff;

endmodule

FILE: rtl/euclidean_distance_matrix_unit.sv
// ----------------------------------------------------------------------------
// Euclidean distance matrix unit
// Stores 16 records of 64 signed Q8.8 elements and returns the floored L2
// distance (unsigned Q11.8) between two stored records.
//
// The req channel takes one item per transfer: a write of one element, which
// marks its record loaded, or a query naming two records. Every item yields
// exactly one transfer on the rsp channel: status 0 for a write, 1 with the
// distance for a query, 2 when a queried record is not loaded.
// The csr channel writes the dimension count (reset 64, clamped to 64) and
// is always ready; write it only while the unit is idle.
// One item is processed at a time. After a write's transfer the sequencer
// steps through dispatch, emit and return before the unit is ready again.
// A query reads one dimension per cycle via both read ports of the record
// memory into the difference/square pipe, then the bit-serial square root.
// The response sits in an output register, so the next request is taken while
// it waits; a stalled receiver only holds the unit once a second response is
// finished. Reset clears the loaded flags, the dimension count to 64 and all
// pending responses; element contents are undefined until written.
// ----------------------------------------------------------------------------
module euclidean_distance_matrix_unit
   import edm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   edm_req_if.sink   req_ch,
   edm_rsp_if.source rsp_ch,
   edm_csr_if.sink   csr_ch
);

   edm_ctl_type  ctl;
   edm_cond_type cond;

   edm_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctl   (ctl)
   );

   edm_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .ctl    (ctl),
      .cond   (cond)
   );

endmodule
